FILE: rtl/assert_macros.svh
// Assertion macros shared by the bit reader RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define JBR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define JBR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/jbr_pkg.sv
// Package for the JPEG bit reader: request and status codes, stuffing bytes,
// queue command struct. No dependencies.
`timescale 1ns / 1ps

package jbr_pkg;

  typedef logic [1:0] req_t;
  typedef logic [1:0] status_t;

  localparam req_t REQ_PUSH = 2'd0;
  localparam req_t REQ_READ = 2'd1;
  localparam req_t REQ_SKIP = 2'd2;
  localparam req_t REQ_END  = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_NRDY  = 2'd1;
  localparam status_t ST_ENDED = 2'd2;

  localparam logic [7:0] STUFF_LEAD = 8'hFF;
  localparam logic [7:0] STUFF_FILL = 8'h00;

  // bytes that must be queued before a read is served ahead of end of data
  localparam int MIN_FILL = 8;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } q_cmd_t;

endpackage

FILE: rtl/jbr_in_if.sv
// Request channel of the bit reader: valid/ready handshake plus request payload.
// Depends on jbr_pkg.
`timescale 1ns / 1ps

interface jbr_in_if;
  import jbr_pkg::*;

  logic                 valid;
  logic                 ready;
  req_t                 req_type;
  logic [7:0]           data_byte;
  logic [COUNT_W-1:0]   bit_count;
  logic                 drop_stuffing;

  modport source (output valid, req_type, data_byte, bit_count, drop_stuffing,
                  input ready);
  modport sink   (input valid, req_type, data_byte, bit_count, drop_stuffing,
                  output ready);
endinterface

FILE: rtl/jbr_out_if.sv
// Result channel of the bit reader: valid/ready handshake plus result payload.
// Depends on jbr_pkg.
`timescale 1ns / 1ps

interface jbr_out_if;
  import jbr_pkg::*;

  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [VALUE_W-1:0]   bits_value;
  logic [COUNT_W-1:0]   bits_taken;
  logic                 at_end;

  modport source (output valid, status, bits_value, bits_taken, at_end,
                  input ready);
  modport sink   (input valid, status, bits_value, bits_taken, at_end,
                  output ready);
endinterface

FILE: rtl/jbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module jbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/jbr_queue.sv
// Circular byte queue: head pointer, fill count and the RAM that holds bytes.
// Depends on jbr_pkg and jbr_ram. Read data is registered and shows the head of the previous cycle.
`timescale 1ns / 1ps

module jbr_queue #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  jbr_pkg::q_cmd_t            cmd,
  output logic [$clog2(DEPTH+1)-1:0] fill,
  output logic [7:0]                 rd_data
);
  import jbr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] waddr;

  // tail = head + fill, wrapped once
  assign tail_sum = {1'b0, head_r} + (AW+1)'(fill_r);
  assign waddr    = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                 : tail_sum[AW-1:0];

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (cmd.push) begin
      fill_nxt = fill_r + FW'(1);
    end else if (cmd.pop && (fill_r != '0)) begin
      fill_nxt = fill_r - FW'(1);
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  jbr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (waddr),
    .wdata (cmd.wdata),
    .raddr (head_r),
    .rdata (rd_data)
  );

  assign fill = fill_r;
endmodule

FILE: rtl/jpeg_bit_reader_unstuffing.sv
// Top level of the JPEG bit reader with byte unstuffing.
// Depends on jbr_pkg, jbr_in_if, jbr_out_if, jbr_queue and assert_macros.svh.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------
//  in_ch    | in  | valid/ready        | req_type, data_byte, bit_count,
//           |     |                    | drop_stuffing
//  out_ch   | out | valid/ready        | status, bits_value, bits_taken, at_end
//
// One request at a time. A refused request, or a push while no hunt is under
// way, goes straight from idle to the result state. A read passes RD_BYTE and
// TAKE per byte it reads, ADV per byte it consumes, and STUF_RD and STUF_CHK
// per byte checked for stuffing; a hunt passes HUNT_RD and HUNT_CHK per byte
// examined. The byte funnel merges one head byte into the accumulator per pass
// through the single RAM read port. Reset is synchronous and clears the queue,
// bit position and stream flags. A result waiting on out_ch holds the sequencer
// in its final state; in_ch is ready only while the sequencer idles.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jpeg_bit_reader_unstuffing #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int MAX_READ_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  jbr_in_if.sink    in_ch,
  jbr_out_if.source out_ch
);
  import jbr_pkg::*;

  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int MRB = MAX_READ_BITS;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RD_BYTE  = 4'd1;  // head address settles into RAM
  localparam logic [3:0] S_TAKE     = 4'd2;  // merge bits of the head byte
  localparam logic [3:0] S_ADV      = 4'd3;  // decide after a byte is consumed
  localparam logic [3:0] S_STUF_RD  = 4'd4;
  localparam logic [3:0] S_STUF_CHK = 4'd5;
  localparam logic [3:0] S_HUNT_RD  = 4'd6;
  localparam logic [3:0] S_HUNT_CHK = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;  // result staged, wait for out slot

  logic [3:0]         state_r, state_nxt;
  req_t               req_r, req_nxt;
  logic               drop_r, drop_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [2:0]         bp_r, bp_nxt;
  logic [MRB-1:0]     acc_r, acc_nxt;
  logic [COUNT_W-1:0] taken_r, taken_nxt;
  status_t            st_r, st_nxt;
  logic               end_seen_r, end_seen_nxt;
  logic               ended_r, ended_nxt;
  logic               hunting_r, hunting_nxt;
  logic [7:0]         marker_r, marker_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r;
  logic [MRB-1:0]     out_value_r;
  logic [COUNT_W-1:0] out_taken_r;
  logic               out_end_r;
  logic               out_load;

  q_cmd_t     q_cmd;
  logic [FW-1:0] q_fill;
  logic [7:0] rd_data;

  logic               accept;
  logic [COUNT_W-1:0] req_bits;

  // byte funnel
  logic [3:0]         avail;
  logic [3:0]         k;
  logic [7:0]         shl;
  logic [7:0]         chunk;
  logic [3:0]         bp_sum;

  // hunt resolution
  logic               fill_ge2;
  logic               hunt_pop;
  logic               hunt_done;
  logic               hunt_ends;
  logic               ended_after;
  status_t            hunt_st;

  jbr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (q_cmd),
    .fill    (q_fill),
    .rd_data (rd_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // saturate the request to the widest read
  assign req_bits = (in_ch.bit_count > COUNT_W'(MRB)) ? COUNT_W'(MRB) : in_ch.bit_count;

  // take min(bits left in head byte, bits still wanted) from the head byte
  assign avail  = 4'd8 - {1'b0, bp_r};
  assign k      = (rem_r < {2'b00, avail}) ? rem_r[3:0] : avail;
  assign shl    = rd_data << bp_r;
  assign chunk  = shl >> (4'd8 - k);
  assign bp_sum = {1'b0, bp_r} + k;

  // hunt: head is the marker, or the queue ran dry
  assign fill_ge2    = (q_fill >= FW'(2));
  assign hunt_done   = fill_ge2 || end_seen_r;
  assign hunt_ends   = !fill_ge2 && end_seen_r;
  assign hunt_pop    = fill_ge2 || (end_seen_r && (q_fill != '0));
  assign ended_after = ended_r || hunt_ends;

  always_comb begin
    case (req_r)
      REQ_SKIP: hunt_st = ended_after ? ST_ENDED : (hunt_done ? ST_OK : ST_NRDY);
      REQ_END:  hunt_st = ended_after ? ST_ENDED : ST_OK;
      default:  hunt_st = ST_OK;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    drop_nxt     = drop_r;
    rem_nxt      = rem_r;
    bp_nxt       = bp_r;
    acc_nxt      = acc_r;
    taken_nxt    = taken_r;
    st_nxt       = st_r;
    end_seen_nxt = end_seen_r;
    ended_nxt    = ended_r;
    hunting_nxt  = hunting_r;
    marker_nxt   = marker_r;
    q_cmd        = '0;
    q_cmd.wdata  = in_ch.data_byte;
    out_load     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_ch.req_type;
          drop_nxt  = in_ch.drop_stuffing;
          acc_nxt   = '0;
          taken_nxt = '0;
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
          unique case (in_ch.req_type)
            REQ_PUSH: begin
              if (end_seen_r || (q_fill >= FW'(QUEUE_DEPTH))) begin
                st_nxt = ST_NRDY;
              end else begin
                q_cmd.push = 1'b1;
                if (hunting_r) begin
                  state_nxt = S_HUNT_RD;
                end
              end
            end
            REQ_READ: begin
              if (hunting_r) begin
                st_nxt = ST_NRDY;
              end else if (ended_r) begin
                st_nxt = ST_ENDED;
              end else if (req_bits == '0) begin
                st_nxt = ST_OK;
              end else if ((q_fill < FW'(MIN_FILL)) && !end_seen_r) begin
                st_nxt = ST_NRDY;
              end else if (q_fill == '0) begin
                ended_nxt = 1'b1;
                st_nxt    = ST_ENDED;
              end else begin
                rem_nxt   = req_bits;
                state_nxt = S_RD_BYTE;
              end
            end
            REQ_SKIP: begin
              if (ended_r) begin
                st_nxt = ST_ENDED;
              end else begin
                // drop the current head, if any, then hunt for the marker
                bp_nxt      = '0;
                q_cmd.pop   = (q_fill != '0);
                marker_nxt  = in_ch.data_byte;
                hunting_nxt = 1'b1;
                state_nxt   = S_HUNT_RD;
              end
            end
            REQ_END: begin
              end_seen_nxt = 1'b1;
              if (hunting_r) begin
                state_nxt = S_HUNT_RD;
              end else begin
                st_nxt = ended_r ? ST_ENDED : ST_OK;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_RD_BYTE: state_nxt = S_TAKE;

      S_TAKE: begin
        acc_nxt   = (acc_r << k) | MRB'(chunk);
        taken_nxt = taken_r + {2'b00, k};
        rem_nxt   = rem_r - {2'b00, k};
        if (bp_sum[3]) begin
          // head byte used up: pop it, maybe drop a stuffed zero behind it
          bp_nxt    = '0;
          q_cmd.pop = 1'b1;
          if (drop_r && (rd_data == STUFF_LEAD) && (q_fill > FW'(1))) begin
            state_nxt = S_STUF_RD;
          end else begin
            state_nxt = S_ADV;
          end
        end else begin
          bp_nxt    = bp_sum[2:0];
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end
      end

      S_STUF_RD: state_nxt = S_STUF_CHK;

      S_STUF_CHK: begin
        q_cmd.pop = (rd_data == STUFF_FILL);
        state_nxt = S_ADV;
      end

      S_ADV: begin
        if (q_fill != '0) begin
          if (rem_r == '0) begin
            st_nxt    = ST_OK;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD_BYTE;
          end
        end else begin
          // queue drained: stop at the byte boundary
          if (end_seen_r) begin
            ended_nxt = 1'b1;
          end
          if (rem_r == '0) begin
            st_nxt = ST_OK;
          end else begin
            st_nxt = end_seen_r ? ST_ENDED : ST_NRDY;
          end
          state_nxt = S_DONE;
        end
      end

      S_HUNT_RD: begin
        if (q_fill == '0) begin
          q_cmd.pop   = hunt_pop;
          hunting_nxt = !hunt_done;
          ended_nxt   = ended_after;
          st_nxt      = hunt_st;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_HUNT_CHK;
        end
      end

      S_HUNT_CHK: begin
        if (rd_data != marker_r) begin
          q_cmd.pop = 1'b1;
          state_nxt = S_HUNT_RD;
        end else begin
          // marker at head: drop it once a byte follows, or at end of data
          q_cmd.pop   = hunt_pop;
          hunting_nxt = !hunt_done;
          ended_nxt   = ended_after;
          st_nxt      = hunt_st;
          state_nxt   = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // hold the result until its transfer; a new one loads only into a free slot
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bp_r        <= '0;
      end_seen_r  <= 1'b0;
      ended_r     <= 1'b0;
      hunting_r   <= 1'b0;
      marker_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bp_r        <= bp_nxt;
      end_seen_r  <= end_seen_nxt;
      ended_r     <= ended_nxt;
      hunting_r   <= hunting_nxt;
      marker_r    <= marker_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    drop_r  <= drop_nxt;
    rem_r   <= rem_nxt;
    acc_r   <= acc_nxt;
    taken_r <= taken_nxt;
    st_r    <= st_nxt;
    if (out_load) begin
      out_status_r <= st_r;
      out_value_r  <= acc_r;
      out_taken_r  <= taken_r;
      out_end_r    <= ended_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.bits_value = VALUE_W'(out_value_r);
  assign out_ch.bits_taken = out_taken_r;
  assign out_ch.at_end     = out_end_r;

  `JBR_ASSERT_ALWAYS(a_hunt_not_ended, !(hunting_r && ended_r), "hunting after stream end")
  `JBR_ASSERT_IMPLY(a_ended_needs_end, ended_r, end_seen_r, "stream ended without end of data")
  `JBR_ASSERT_IMPLY(a_bitpos_has_head, bp_r != 3'd0, q_fill != '0, "bit position without head")
  `JBR_ASSERT_IMPLY(a_take_has_work, state_r == S_TAKE, rem_r != '0, "byte funnel with no bits")
endmodule
